>>> rtl/core/xtbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block decrypt package
// Shared widths, constants, types and the round mixing function.
// ----------------------------------------------------------------------------
package xtbd_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
    localparam int ROUND_COUNT = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

    // Half-round selectors.
    localparam logic HALF_RIGHT = 1'b0;
    localparam logic HALF_LEFT  = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } block_t;

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
        mix = ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Running sum for a given number of rounds still to go, modulo 2^32.
    function automatic logic [WORD_W-1:0] round_sum(input int rounds_left);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, DELTA} * (2*WORD_W)'(rounds_left);
        round_sum = prod[WORD_W-1:0];
    endfunction

endpackage

>>> rtl/core/xtbd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA half-round cell
// One Feistel half-round with a fixed sum; registers the block and its valid.
// ----------------------------------------------------------------------------
module xtbd_cell #(
    parameter logic                          HALF = xtbd_pkg::HALF_RIGHT,
    parameter logic [xtbd_pkg::WORD_W-1:0]   SUM  = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  xtbd_pkg::key_t   key,
    input  logic             valid_in,
    input  xtbd_pkg::block_t block_in,
    output logic             valid_out,
    output xtbd_pkg::block_t block_out
);

    // The key word is picked by sum bits, which are fixed for this cell.
    localparam logic [xtbd_pkg::KEY_IDX_W-1:0] KEY_SEL =
        (HALF == xtbd_pkg::HALF_LEFT) ? SUM[xtbd_pkg::KEY_IDX_W-1:0]
                                      : SUM[11 +: xtbd_pkg::KEY_IDX_W];

    logic             valid_reg;
    xtbd_pkg::block_t block_reg;
    xtbd_pkg::block_t block_next;
    logic [xtbd_pkg::WORD_W-1:0] mix_val;
    logic [xtbd_pkg::WORD_W-1:0] key_val;

    always_comb
    begin
        block_next = block_in;
        if (HALF == xtbd_pkg::HALF_LEFT)
        begin
            mix_val         = xtbd_pkg::mix(block_in.right);
            key_val         = SUM + key[KEY_SEL];
            block_next.left = block_in.left - (mix_val ^ key_val);
        end
        else
        begin
            mix_val          = xtbd_pkg::mix(block_in.left);
            key_val          = SUM + key[KEY_SEL];
            block_next.right = block_in.right - (mix_val ^ key_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            block_reg <= block_next;
        end
    end

    assign valid_out = valid_reg;
    assign block_out = block_reg;

endmodule

>>> rtl/core/xtbd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA output buffer
// Output register plus skid entry; halts the cell chain only when both hold.
// ----------------------------------------------------------------------------
module xtbd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             chain_valid,
    input  xtbd_pkg::block_t chain_block,
    output logic             chain_enable,
    output logic             out_valid,
    input  logic             out_ready,
    output xtbd_pkg::block_t out_block
);

    logic             out_valid_reg;
    xtbd_pkg::block_t out_block_reg;
    logic             skid_valid_reg;
    xtbd_pkg::block_t skid_block_reg;
    logic             take;

    assign take         = !out_valid_reg || out_ready;
    assign chain_enable = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= chain_valid;
            end
        end
        else if (chain_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_block_reg <= skid_valid_reg ? skid_block_reg : chain_block;
        end
        else if (!skid_valid_reg)
        begin
            skid_block_reg <= chain_block;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_block = out_block_reg;

endmodule

>>> rtl/core/xtea_block_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block decrypt
// Pipelined XTEA decryption of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
//  Channel   Signals                                    Direction
//  config    cfg_we, cfg_index, cfg_data                write only
//  input     in_valid/in_ready, cipher_left/right       request in
//  output    out_valid/out_ready, plain_left/right      request out
//
//  One request is taken per cycle while in_ready is high; the data path is a
//  row of 2*ROUND_COUNT half-round cells followed by the output register.
//  Reset clears the key words and all valid bits; no clearing pass is needed.
//  A stalled output fills the skid entry, after which in_ready drops and the
//  whole cell row holds until the skid entry drains.
// ----------------------------------------------------------------------------
module xtea_block_decrypt #(
    parameter int ROUND_COUNT = xtbd_pkg::ROUND_COUNT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [xtbd_pkg::KEY_IDX_W-1:0]    cfg_index,
    input  logic [xtbd_pkg::WORD_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [xtbd_pkg::WORD_W-1:0]       cipher_left,
    input  logic [xtbd_pkg::WORD_W-1:0]       cipher_right,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [xtbd_pkg::WORD_W-1:0]       plain_left,
    output logic [xtbd_pkg::WORD_W-1:0]       plain_right
);

    localparam int CELLS = 2 * ROUND_COUNT;

    xtbd_pkg::key_t   key_reg;
    logic             enable;
    logic             valid_chain [CELLS+1];
    xtbd_pkg::block_t block_chain [CELLS+1];
    xtbd_pkg::block_t out_block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    assign in_ready             = enable;
    assign valid_chain[0]       = in_valid;
    assign block_chain[0].left  = cipher_left;
    assign block_chain[0].right = cipher_right;

    // Even cells update the right word, odd cells the left word after the
    // sum has been lowered by one delta.
    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        localparam logic HALF = (c % 2 == 1) ? xtbd_pkg::HALF_LEFT
                                             : xtbd_pkg::HALF_RIGHT;
        localparam logic [xtbd_pkg::WORD_W-1:0] SUM =
            xtbd_pkg::round_sum(ROUND_COUNT - c / 2 - c % 2);

        xtbd_cell #(
            .HALF (HALF),
            .SUM  (SUM)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (enable),
            .key       (key_reg),
            .valid_in  (valid_chain[c]),
            .block_in  (block_chain[c]),
            .valid_out (valid_chain[c+1]),
            .block_out (block_chain[c+1])
        );
    end

    xtbd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .chain_valid  (valid_chain[CELLS]),
        .chain_block  (block_chain[CELLS]),
        .chain_enable (enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_block    (out_block)
    );

    assign plain_left  = out_block.left;
    assign plain_right = out_block.right;

endmodule

>>> sim/xtea_block_decrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block decrypt checker
// Follows the key writes, deciphers every accepted ciphertext request on its
// own and compares each plaintext request that leaves the block, in order.
// ----------------------------------------------------------------------------
module xtea_block_decrypt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [xtbd_pkg::KEY_IDX_W-1:0] cfg_index,
    input  logic [xtbd_pkg::WORD_W-1:0]    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [xtbd_pkg::WORD_W-1:0]    cipher_left,
    input  logic [xtbd_pkg::WORD_W-1:0]    cipher_right,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [xtbd_pkg::WORD_W-1:0]    plain_left,
    input  logic [xtbd_pkg::WORD_W-1:0]    plain_right,
    output int                             fail_count,
    output int                             plain_pending
);

    localparam int REPORT_LIMIT = 10;

    xtbd_pkg::key_t   key_copy;
    xtbd_pkg::block_t expected_plain[$];
    xtbd_pkg::block_t oldest;

    initial
    begin
        fail_count    = 0;
        plain_pending = 0;
        key_copy      = '0;
    end

    function automatic logic [xtbd_pkg::WORD_W-1:0] spread(
        input logic [xtbd_pkg::WORD_W-1:0] x);
        spread = ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic xtbd_pkg::block_t decipher_block(
        input xtbd_pkg::key_t k,
        input logic [xtbd_pkg::WORD_W-1:0] cl,
        input logic [xtbd_pkg::WORD_W-1:0] cr);
        logic [xtbd_pkg::WORD_W-1:0] l;
        logic [xtbd_pkg::WORD_W-1:0] r;
        logic [xtbd_pkg::WORD_W-1:0] s;
        xtbd_pkg::block_t            res;
        l = cl;
        r = cr;
        // The product wraps at 32 bits, giving 0xC6EF3720 for 32 rounds.
        s = xtbd_pkg::DELTA * xtbd_pkg::WORD_W'(xtbd_pkg::ROUND_COUNT);
        for (int i = 0; i < xtbd_pkg::ROUND_COUNT; i++)
        begin
            r = r - (spread(l) ^ (s + k[s[12:11]]));
            s = s - xtbd_pkg::DELTA;
            l = l - (spread(r) ^ (s + k[s[1:0]]));
        end
        res.left  = l;
        res.right = r;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_copy = '0;
            expected_plain.delete();
            plain_pending = 0;
        end
        else
        begin
            if (cfg_we)
                key_copy[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                expected_plain.push_back(decipher_block(key_copy, cipher_left, cipher_right));
            if (out_valid && out_ready)
            begin
                if (expected_plain.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected plaintext request %h %h",
                                 $realtime, plain_left, plain_right);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_plain.pop_front();
                    if (oldest.left !== plain_left || oldest.right !== plain_right)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display("%0t: plaintext mismatch: expected %h %h, got %h %h",
                                     $realtime, oldest.left, oldest.right,
                                     plain_left, plain_right);
                        fail_count++;
                    end
                end
            end
            plain_pending = expected_plain.size();
        end
    end

endmodule

>>> sim/xtea_block_decrypt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block decrypt testbench
// Drives ciphertext requests under a series of keys, with random gaps and
// stalls on both channels, and leaves checking to the checker beside the block.
// ----------------------------------------------------------------------------
module xtea_block_decrypt_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY     = 2 * xtbd_pkg::ROUND_COUNT + 1;
    localparam int HOLD_CYCLES = 400;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [xtbd_pkg::KEY_IDX_W-1:0] cfg_index    = '0;
    logic [xtbd_pkg::WORD_W-1:0]    cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [xtbd_pkg::WORD_W-1:0]    cipher_left  = '0;
    logic [xtbd_pkg::WORD_W-1:0]    cipher_right = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic [xtbd_pkg::WORD_W-1:0]    plain_left;
    logic [xtbd_pkg::WORD_W-1:0]    plain_right;

    int fail_count;
    int plain_pending;
    int cycle_count = 0;
    int tx_idle_pct = 20;
    int rx_idle_pct = 47;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    xtea_block_decrypt dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cipher_left  (cipher_left),
        .cipher_right (cipher_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .plain_left   (plain_left),
        .plain_right  (plain_right)
    );

    xtea_block_decrypt_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cipher_left   (cipher_left),
        .cipher_right  (cipher_right),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .plain_left    (plain_left),
        .plain_right   (plain_right),
        .fail_count    (fail_count),
        .plain_pending (plain_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL xtea_block_decrypt");
            $finish;
        end
    end

    // Receiver: random stalls, or one long hold-off when the stimulus asks.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [xtbd_pkg::WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: pick_word = '0;
            1: pick_word = '1;
            2: pick_word = xtbd_pkg::WORD_W'(1) << $urandom_range(xtbd_pkg::WORD_W - 1);
            3: pick_word = ~(xtbd_pkg::WORD_W'(1) << $urandom_range(xtbd_pkg::WORD_W - 1));
            default: pick_word = $urandom;
        endcase
    endfunction

    // Called right after an edge; valid stays high between back-to-back requests.
    task automatic send_block(input logic [xtbd_pkg::WORD_W-1:0] l,
                              input logic [xtbd_pkg::WORD_W-1:0] r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cipher_left  <= l;
        cipher_right <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (plain_pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_key(input xtbd_pkg::key_t k);
        for (int i = 0; i < xtbd_pkg::KEY_WORDS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= xtbd_pkg::KEY_IDX_W'(i);
            cfg_data  <= k[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_random_key();
        xtbd_pkg::key_t k;
        int             sel;
        sel = $urandom_range(7);
        for (int i = 0; i < xtbd_pkg::KEY_WORDS; i++)
        begin
            case (sel)
                0: k[i] = '0;
                1: k[i] = '1;
                2: k[i] = pick_word();
                default: k[i] = $urandom;
            endcase
        end
        load_key(k);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int until_rekey;
        until_rekey = $urandom_range(60, 140);
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == 20)
                hold_req = 1'b1;
            if (until_rekey == 0)
            begin
                drain();
                load_random_key();
                until_rekey = $urandom_range(60, 140);
            end
            until_rekey--;
            send_block(pick_word(), pick_word());
        end
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Key never written, so every word reads as zero.
        send_block('0, '0);
        send_block('1, '1);
        send_block('1, '0);
        send_block('0, '1);
        send_block(32'hAAAAAAAA, 32'h55555555);
        send_block(32'h80000000, 32'h00000001);
        drain();

        load_key('1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(32'h55555555, 32'hAAAAAAAA);
        send_block(32'h00000001, 32'h80000000);
        drain();

        load_key({32'h0C0D0E0F, 32'h08090A0B, 32'h04050607, 32'h00010203});
        send_block(32'h89ABCDEF, 32'h01234567);
        send_block('0, '1);
        send_block(32'hDEADBEEF, 32'hCAFEF00D);
        drain();

        // One word at a time set, to show which sum bits pick the key word.
        for (int i = 0; i < xtbd_pkg::KEY_WORDS; i++)
        begin
            load_key(xtbd_pkg::key_t'(128'hFFFFFFFF << (xtbd_pkg::WORD_W * i)));
            send_block(32'h12345678, 32'h9ABCDEF0);
            send_block('0, '0);
            drain();
        end

        tx_idle_pct = 20;
        rx_idle_pct = 47;
        run_random(520, 1'b1);

        tx_idle_pct = 47;
        rx_idle_pct = 20;
        load_random_key();
        run_random(520, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_random_key();
        run_random(490, 1'b0);

        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && plain_pending == 0)
            $display("PASS xtea_block_decrypt");
        else
            $display("FAIL xtea_block_decrypt");
        $finish;
    end

endmodule
